### sv/symmetric_half_band_fir_defines.svh
// ----------------------------------------------------------------------------
// symmetric_half_band_fir_defines.svh
// assertion macros for the half-band fir checker
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_HALF_BAND_FIR_DEFINES_SVH
`define SYMMETRIC_HALF_BAND_FIR_DEFINES_SVH

// concurrent check, muted while reset is high
`define HBF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent check that also runs across reset
`define HBF_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/hbf_pkg.sv
// ----------------------------------------------------------------------------
// hbf_pkg
// widths, codes and control types of the half-band fir
// ----------------------------------------------------------------------------
package hbf_pkg;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 18;
   localparam int SLOT_W   = 5;
   localparam int PAIR_W   = SAMPLE_W + 1;
   localparam int PROD_W   = COEF_W + PAIR_W;

   // parameter defaults
   localparam int MAX_LENGTH_DEF   = 65;
   localparam int COEF_ENTRIES_DEF = 17;

   // rounding from scale 2^-40 down to q1.23
   localparam int ROUND_SHIFT = 17;
   localparam int OUT_MAX     = 8388607;
   localparam int OUT_MIN     = -8388608;

   // request commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // length select reset value (65 taps)
   localparam logic LONG_LENGTH_RST = 1'b1;

   // control broadcast to every tap cell
   typedef struct packed {
      logic                     sample_fire;
      logic                     load_fire;
      logic                     long_sel;
      logic [SLOT_W-1:0]        slot;
      logic signed [COEF_W-1:0] coef;
   } hbf_ctrl_type;

endpackage

### sv/hbf_delay_line.sv
// ----------------------------------------------------------------------------
// hbf_delay_line
// sample shift chain, shows the tap values after the next push
// ----------------------------------------------------------------------------
module hbf_delay_line
   import hbf_pkg::*;
#(
   parameter int NTAP = MAX_LENGTH_DEF - 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic signed [SAMPLE_W-1:0] tap_next [NTAP]
);

   logic signed [SAMPLE_W-1:0] taps_ff [NTAP];

   always_comb begin
      tap_next[0] = sample_in;
      for (int i = 1; i < NTAP; i++) begin
         tap_next[i] = taps_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAP; i++) begin
            taps_ff[i] <= '0;
         end
      end else if (shift) begin
         for (int i = 0; i < NTAP; i++) begin
            taps_ff[i] <= tap_next[i];
         end
      end
   end

endmodule

### sv/hbf_cell.sv
// ----------------------------------------------------------------------------
// hbf_cell
// one folded tap: coefficient entry, running pair sums and product register
// ----------------------------------------------------------------------------
module hbf_cell
   import hbf_pkg::*;
#(
   parameter int SLOT = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hbf_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] tap_a_l,
   input  logic signed [SAMPLE_W-1:0] tap_b_l,
   input  logic signed [SAMPLE_W-1:0] tap_a_s,
   input  logic signed [SAMPLE_W-1:0] tap_b_s,
   output logic signed [PROD_W-1:0]   product
);

   localparam int CMP_W = SLOT_W + 1;

   logic signed [COEF_W-1:0] coef_ff;
   logic signed [PAIR_W-1:0] pair_l_ff;
   logic signed [PAIR_W-1:0] pair_l_in;
   logic signed [PAIR_W-1:0] pair_s_ff;
   logic signed [PAIR_W-1:0] pair_s_in;
   logic signed [PAIR_W-1:0] pair_sel;
   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic                     load_hit;

   assign load_hit  = ctrl.load_fire && ({1'b0, ctrl.slot} == CMP_W'(SLOT));
   // pair sums as they will be once the new sample is pushed
   assign pair_l_in = PAIR_W'(tap_a_l) + PAIR_W'(tap_b_l);
   assign pair_s_in = PAIR_W'(tap_a_s) + PAIR_W'(tap_b_s);
   assign pair_sel  = ctrl.long_sel ? pair_l_ff : pair_s_ff;
   assign product_in = coef_ff * pair_sel;
   assign product   = product_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_l_ff <= '0;
         pair_s_ff <= '0;
      end else if (ctrl.sample_fire) begin
         pair_l_ff <= pair_l_in;
         pair_s_ff <= pair_s_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         coef_ff <= ctrl.coef;
      end
      if (ctrl.sample_fire) begin
         product_ff <= product_in;
      end
   end

endmodule

### sv/hbf_sum_tree.sv
// ----------------------------------------------------------------------------
// hbf_sum_tree
// registered binary adder tree, one level per stage, stalls level by level
// ----------------------------------------------------------------------------
module hbf_sum_tree
   import hbf_pkg::*;
#(
   parameter int N_IN  = COEF_ENTRIES_DEF,
   parameter int IN_W  = PROD_W,
   parameter int OUT_W = PROD_W + $clog2(COEF_ENTRIES_DEF)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [IN_W-1:0]  leaf_in [N_IN],
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] sum_out
);

   localparam int LEVELS = $clog2(N_IN);
   localparam int N_PAD  = 1 << LEVELS;

   logic signed [OUT_W-1:0] leaf [N_PAD];
   logic signed [OUT_W-1:0] node_ff [N_PAD-1];
   logic [LEVELS-1:0]       vld_ff;
   logic [LEVELS-1:0]       en;

   // level 0 is the root, level LEVELS-1 sits next to the leaves
   always_comb begin
      en[0] = !vld_ff[0] || out_ready;
      for (int d = 1; d < LEVELS; d++) begin
         en[d] = !vld_ff[d] || en[d-1];
      end
   end

   assign in_ready  = en[LEVELS-1];
   assign out_valid = vld_ff[0];
   assign sum_out   = node_ff[0];

   for (genvar j = 0; j < N_PAD; j++) begin : g_leaf
      if (j < N_IN) begin : g_used
         assign leaf[j] = OUT_W'(leaf_in[j]);
      end else begin : g_pad
         assign leaf[j] = '0;
      end
   end

   for (genvar d = 0; d < LEVELS; d++) begin : g_vld
      if (d == LEVELS - 1) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[d] <= 1'b0;
            end else if (en[d]) begin
               vld_ff[d] <= in_valid;
            end
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[d] <= 1'b0;
            end else if (en[d]) begin
               vld_ff[d] <= vld_ff[d+1];
            end
         end
      end
   end

   // heap numbering: node i has children 2i and 2i+1
   for (genvar i = 1; i < N_PAD; i++) begin : g_node
      localparam int D = $clog2(i + 1) - 1;
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
      if (2 * i >= N_PAD) begin : g_from_leaf
         assign left  = leaf[2*i-N_PAD];
         assign right = leaf[2*i+1-N_PAD];
      end else begin : g_from_node
         assign left  = node_ff[2*i-1];
         assign right = node_ff[2*i];
      end
      always_ff @(posedge clock) begin
         if (en[D]) begin
            node_ff[i-1] <= left + right;
         end
      end
   end

endmodule

### sv/symmetric_half_band_fir.sv
// ----------------------------------------------------------------------------
// symmetric_half_band_fir
// half-band fir of 33 or 65 taps, folded symmetric taps, q1.23 in and out
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              carries
//   csr_      in          csr_valid/csr_ready    long_length (1 = 65 taps)
//   req_      in          req_valid/req_ready    command, sample or coef load
//   rsp_      out         rsp_valid/rsp_ready    sample_out, clipped
//
// one request transaction per clock when the result side keeps up; at a
// sample's accepting edge the cells register its pair sums and capture the
// products of the pair sums held from the sample before; these then pass
// each level of the registered adder tree and then the output register.
// sync reset clears the delay line, the pair sums and all valid flags; the
// coefficient entries hold garbage until loaded.
// a stalled result holds the output register; stages behind it keep filling
// until the product stage is full, then req_ready drops.
// load transactions give no response and never disturb the delay line.
// ----------------------------------------------------------------------------
module symmetric_half_band_fir
   import hbf_pkg::*;
#(
   parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
   parameter int COEF_ENTRIES = COEF_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // config write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_long_length,
   // requests
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_command,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic [SLOT_W-1:0]          req_coef_slot,
   input  logic signed [COEF_W-1:0]   req_coef_value,
   // responses
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_clipped
);

   // filter geometry
   localparam int NTAP         = MAX_LENGTH - 2;          // taps ever read
   localparam int SHORT_LENGTH = (MAX_LENGTH + 1) / 2;
   localparam int MID_L        = MAX_LENGTH / 2;
   localparam int MID_S        = SHORT_LENGTH / 2;
   localparam int PAIRS_L_RAW  = MID_L / 2;
   localparam int PAIRS_S_RAW  = MID_S / 2;
   localparam int NPAIR_L      = (PAIRS_L_RAW < COEF_ENTRIES - 1) ?
                                 PAIRS_L_RAW : COEF_ENTRIES - 1;
   localparam int NPAIR_S      = (PAIRS_S_RAW < COEF_ENTRIES - 1) ?
                                 PAIRS_S_RAW : COEF_ENTRIES - 1;
   localparam int NCELL        = NPAIR_L + 1;             // pairs plus center
   localparam int CENTER_SLOT  = COEF_ENTRIES - 1;
   localparam int CTR_L        = MID_L - 1;
   localparam int CTR_S        = MID_S - 1;

   // accumulator and rounding widths
   localparam int ACC_W = PROD_W + $clog2(NCELL);
   localparam int RND_W = ACC_W + 1;
   localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [RND_W-1:0] SAT_HI     = RND_W'(OUT_MAX);
   localparam logic signed [RND_W-1:0] SAT_LO     = RND_W'(OUT_MIN);

   logic                       long_length_ff;
   hbf_ctrl_type               ctrl;
   logic                       req_fire;
   logic signed [SAMPLE_W-1:0] tap_next [NTAP];
   logic signed [PROD_W-1:0]   product [NCELL];

   logic                       prod_vld_ff;
   logic                       prod_en;
   logic                       tree_in_ready;
   logic                       tree_out_valid;
   logic signed [ACC_W-1:0]    tree_sum;

   logic                       out_en;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_out_ff;
   logic                       rsp_clipped_ff;
   logic signed [RND_W-1:0]    rounded;
   logic signed [RND_W-1:0]    scaled;
   logic signed [SAMPLE_W-1:0] sat_value;
   logic                       sat_hit;

   // ------------------------------------------------------------------
   // config register, always writable
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_length_ff <= LONG_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         long_length_ff <= csr_long_length;
      end
   end

   // ------------------------------------------------------------------
   // request decode; a load just writes one cell's coefficient
   // ------------------------------------------------------------------
   assign req_ready = prod_en;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      ctrl.sample_fire = req_fire && (req_command == CMD_SAMPLE);
      ctrl.load_fire   = req_fire && (req_command == CMD_LOAD);
      ctrl.long_sel    = long_length_ff;
      ctrl.slot        = req_coef_slot;
      ctrl.coef        = req_coef_value;
   end

   // ------------------------------------------------------------------
   // delay line, pushed once per sample transaction
   // ------------------------------------------------------------------
   hbf_delay_line #(
      .NTAP (NTAP)
   ) u_delay_line (
      .clock     (clock),
      .reset     (reset),
      .shift     (ctrl.sample_fire),
      .sample_in (req_sample_in),
      .tap_next  (tap_next)
   );

   // ------------------------------------------------------------------
   // tap cells: cell k folds taps 2k and len-3-2k, the last is the center
   // the current sample is tap 0, the other taps are the ones already held
   // ------------------------------------------------------------------
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      logic signed [SAMPLE_W-1:0] tap_a_l;
      logic signed [SAMPLE_W-1:0] tap_b_l;
      logic signed [SAMPLE_W-1:0] tap_a_s;
      logic signed [SAMPLE_W-1:0] tap_b_s;

      if (k < NPAIR_L) begin : g_pair
         assign tap_a_l = tap_next[2*k];
         assign tap_b_l = tap_next[MAX_LENGTH-3-2*k];
         if (k < NPAIR_S) begin : g_short
            assign tap_a_s = tap_next[2*k];
            assign tap_b_s = tap_next[SHORT_LENGTH-3-2*k];
         end else begin : g_long_only
            // unused in 33-tap mode, product comes out zero
            assign tap_a_s = '0;
            assign tap_b_s = '0;
         end
         hbf_cell #(
            .SLOT (k)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .tap_a_l (tap_a_l),
            .tap_b_l (tap_b_l),
            .tap_a_s (tap_a_s),
            .tap_b_s (tap_b_s),
            .product (product[k])
         );
      end else begin : g_center
         // center tap has no mirror partner
         assign tap_a_l = tap_next[CTR_L];
         assign tap_b_l = '0;
         assign tap_a_s = tap_next[CTR_S];
         assign tap_b_s = '0;
         hbf_cell #(
            .SLOT (CENTER_SLOT)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .tap_a_l (tap_a_l),
            .tap_b_l (tap_b_l),
            .tap_a_s (tap_a_s),
            .tap_b_s (tap_b_s),
            .product (product[k])
         );
      end
   end

   // ------------------------------------------------------------------
   // product stage valid; the products themselves live in the cells
   // ------------------------------------------------------------------
   assign prod_en = !prod_vld_ff || tree_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (prod_en) begin
         prod_vld_ff <= ctrl.sample_fire;
      end
   end

   hbf_sum_tree #(
      .N_IN  (NCELL),
      .IN_W  (PROD_W),
      .OUT_W (ACC_W)
   ) u_sum_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_vld_ff),
      .in_ready  (tree_in_ready),
      .leaf_in   (product),
      .out_valid (tree_out_valid),
      .out_ready (out_en),
      .sum_out   (tree_sum)
   );

   // ------------------------------------------------------------------
   // round half up to q1.23, saturate, output register
   // ------------------------------------------------------------------
   assign rounded = RND_W'(tree_sum) + ROUND_BIAS;
   assign scaled  = rounded >>> ROUND_SHIFT;

   always_comb begin
      priority if (scaled > SAT_HI) begin
         sat_hit   = 1'b1;
         sat_value = SAMPLE_W'(OUT_MAX);
      end else if (scaled < SAT_LO) begin
         sat_hit   = 1'b1;
         sat_value = SAMPLE_W'(OUT_MIN);
      end else begin
         sat_hit   = 1'b0;
         sat_value = scaled[SAMPLE_W-1:0];
      end
   end

   assign out_en = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= tree_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && tree_out_valid) begin
         rsp_sample_out_ff <= sat_value;
         rsp_clipped_ff    <= sat_hit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

### sv/hbf_checker.sv
// ----------------------------------------------------------------------------
// hbf_checker
// port-level checks on the half-band fir, bound to the top level
// ----------------------------------------------------------------------------
`include "symmetric_half_band_fir_defines.svh"

module hbf_checker
   import hbf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_clipped
);

   localparam logic signed [SAMPLE_W-1:0] RAIL_HI = SAMPLE_W'(OUT_MAX);
   localparam logic signed [SAMPLE_W-1:0] RAIL_LO = SAMPLE_W'(OUT_MIN);

   // reset leaves nothing in flight and the request side open
   `HBF_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid && req_ready, "not empty after reset")

   // a stalled response holds its transaction
   `HBF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped), "response dropped or changed under stall")

   // backpressure only comes from a blocked response
   `HBF_ASSERT(a_stall_cause, !req_ready |-> rsp_valid && !rsp_ready, "request stalled without a blocked response")

   // a clipped sample sits on one of the rails
   `HBF_ASSERT(a_clip_rail, rsp_valid && rsp_clipped |-> rsp_sample_out == RAIL_HI || rsp_sample_out == RAIL_LO, "clipped sample off the rails")

endmodule

bind symmetric_half_band_fir hbf_checker u_hbf_checker (.*);
